// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stepper sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ===== sv/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper step sequencer package
// Item types, the full-step coil table and register map constants.
// ----------------------------------------------------------------------------
package sss_pkg;

   // Full-step sequence: four phases
   localparam int unsigned PHASE_COUNT = 4;
   localparam int unsigned PHASE_W     = $clog2(PHASE_COUNT);

   localparam logic [3:0] COIL_TABLE [PHASE_COUNT] = '{
      4'b1010, 4'b0110, 4'b0101, 4'b1001
   };

   // Register map: tick_divide at byte address 0
   localparam int unsigned CSR_ADDR_W        = 3;
   localparam logic        CSR_SEL_TICK_DIV  = 1'b0;
   localparam logic [7:0]  TICK_DIVIDE_RESET = 8'd2;

   // One timer tick
   typedef struct packed {
      logic        enable;
      logic        direction;
      logic [7:0]  speed;
      logic [15:0] step_target;
   } item_type;

   // One result per tick
   typedef struct packed {
      logic [3:0]  coil_pattern;
      logic        stepped;
      logic [15:0] steps_left;
   } result_type;

endpackage

// ===== sv/sss_motor_core.sv =====
// ----------------------------------------------------------------------------
// Stepper motor core
// Prescaler and motor step state; computes the next state and the result
// of one tick in a single pass and commits it when the tick fires.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sss_motor_core
   import sss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  logic [7:0] tick_divide,
   output result_type result
);

   logic [7:0]         prescale_ff,    prescale_in;
   logic [15:0]        last_target_ff, last_target_in;
   logic [15:0]        remaining_ff,   remaining_in;
   logic [7:0]         last_speed_ff,  last_speed_in;
   logic [7:0]         speed_count_ff, speed_count_in;
   logic [PHASE_W-1:0] phase_ff,       phase_in;
   logic [3:0]         coil_ff,        coil_in;
   logic               motor_run;
   logic               take_step;

   // Next state for one tick; nothing moves unless the tick fires
   always_comb begin
      prescale_in    = prescale_ff;
      last_target_in = last_target_ff;
      remaining_in   = remaining_ff;
      last_speed_in  = last_speed_ff;
      speed_count_in = speed_count_ff;
      phase_in       = phase_ff;
      coil_in        = coil_ff;
      take_step      = 1'b0;
      motor_run      = (prescale_ff >= tick_divide);
      if (fire) begin
         if (!motor_run) begin
            prescale_in = prescale_ff + 8'd1;
         end else begin
            prescale_in = '0;
            if (item.enable) begin
               if (last_target_ff != item.step_target) begin
                  // new target restarts the step count
                  last_target_in = item.step_target;
                  remaining_in   = item.step_target;
               end else if (remaining_ff != '0) begin
                  if (last_speed_ff != item.speed) begin
                     last_speed_in  = item.speed;
                     speed_count_in = item.speed;
                  end else if (speed_count_ff != '0) begin
                     speed_count_in = speed_count_ff - 8'd1;
                  end else begin
                     // latch coils, advance phase, consume one step
                     take_step      = 1'b1;
                     coil_in        = COIL_TABLE[phase_ff];
                     speed_count_in = last_speed_ff;
                     phase_in       = item.direction ? phase_ff + 1'b1 : phase_ff - 1'b1;
                     remaining_in   = remaining_ff - 16'd1;
                  end
               end
            end
         end
      end
   end

   // Result reflects the state after this tick
   assign result = '{coil_pattern: coil_in, stepped: take_step, steps_left: remaining_in};

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff    <= '0;
         last_target_ff <= '0;
         remaining_ff   <= '0;
         last_speed_ff  <= '0;
         speed_count_ff <= '0;
         phase_ff       <= '0;
         coil_ff        <= '0;
      end else begin
         prescale_ff    <= prescale_in;
         last_target_ff <= last_target_in;
         remaining_ff   <= remaining_in;
         last_speed_ff  <= last_speed_in;
         speed_count_ff <= speed_count_in;
         phase_ff       <= phase_in;
         coil_ff        <= coil_in;
      end
   end

   `ASSERT_IMPLIES(a_step_needs_steps, clock, reset, take_step, remaining_ff != '0)
   `ASSERT_NEXT(a_step_moves_phase, clock, reset, take_step, phase_ff != $past(phase_ff))
   `ASSERT_NEXT(a_skip_tick_no_motion, clock, reset, fire && !motor_run,
      $stable(remaining_ff) && $stable(coil_ff) && $stable(phase_ff))

endmodule

// ===== sv/stepper_step_sequencer.sv =====
// ----------------------------------------------------------------------------
// Stepper step sequencer
// Full-step stepper motor sequencer, one channel: timer ticks in, coil
// pattern, step strobe and remaining step count out.
// ----------------------------------------------------------------------------
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_ready     enable, direction, speed, step_target
//   rsp       out         rsp_valid / rsp_ready     coil_pattern, stepped, steps_left
//   csr       in/out      APB psel/penable/pready   tick_divide at byte address 0
//
// One item per cycle sustained while rsp_ready stays high; each item
// passes the input register, then the result register, which lie around
// the single-pass motor update logic.
// Synchronous reset clears all motor state and sets tick_divide to 2.
// A stalled result holds the result register; the input register then
// fills and req_ready drops until rsp_ready returns.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_step_sequencer
   import sss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tick input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_enable,
   input  logic                  req_direction,
   input  logic [7:0]            req_speed,
   input  logic [15:0]           req_step_target,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_coil_pattern,
   output logic                  rsp_stepped,
   output logic [15:0]           rsp_steps_left,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic       s1_valid_ff,  s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type core_result;
   logic [7:0] tick_divide_ff;
   logic       out_free;
   logic       s1_adv;
   logic       req_accept;
   logic       csr_write;

   // Handshake: the result register frees the input register
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture item and result
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= '{enable: req_enable, direction: req_direction,
                         speed: req_speed, step_target: req_step_target};
      end
      if (s1_adv) begin
         rsp_data_ff <= core_result;
      end
   end

   // Motor update runs as the item moves into the result register
   sss_motor_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (s1_adv),
      .item        (s1_item_ff),
      .tick_divide (tick_divide_ff),
      .result      (core_result)
   );

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divide_ff <= TICK_DIVIDE_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_SEL_TICK_DIV)) begin
         tick_divide_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_SEL_TICK_DIV) ? {24'd0, tick_divide_ff} : 32'd0;

   // Drive result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coil_pattern = rsp_data_ff.coil_pattern;
   assign rsp_stepped      = rsp_data_ff.stepped;
   assign rsp_steps_left   = rsp_data_ff.steps_left;

   `ASSERT_IMPLIES(a_step_drives_coils, clock, reset, rsp_valid_ff && rsp_data_ff.stepped,
      rsp_data_ff.coil_pattern != 4'd0)
   `ASSERT_NEXT(a_s1_holds_on_stall, clock, reset, s1_valid_ff && !out_free,
      s1_valid_ff && $stable(s1_item_ff))

endmodule

// ===== test/stepper_step_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// Stepper step sequencer testbench
// Drives timer ticks through the valid/ready input, programs tick_divide over
// the APB port between phases, and checks every result field against an
// in-bench model of the prescaler, step counter, speed divider and phase walk.
// Covers directed corner cases, then random motor moves under several idle and
// stall mixes, and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module stepper_step_sequencer_tb
   import sss_pkg::*;
();

   localparam int unsigned          HOLD_OFF_CYCLES = 200;
   localparam int unsigned          STALL_LIMIT     = 3000;
   localparam int unsigned          SETTLE_CYCLES   = 6;
   localparam logic [CSR_ADDR_W-1:0] TICK_DIVIDE_ADDR = '0;
   localparam logic [7:0]           DIVIDE_AT_RESET = 8'd2;
   localparam logic [3:0]           FULL_STEP_COILS [4] = '{
      4'b1010, 4'b0110, 4'b0101, 4'b1001
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_enable = 1'b0;
   logic                  req_direction = 1'b0;
   logic [7:0]            req_speed = '0;
   logic [15:0]           req_step_target = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [3:0]            rsp_coil_pattern;
   logic                  rsp_stepped;
   logic [15:0]           rsp_steps_left;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // model state, mirrors the motor logic of one channel
   logic [7:0]  divide_setting  = DIVIDE_AT_RESET;
   logic [7:0]  prescale_now    = '0;
   logic [15:0] target_seen     = '0;
   logic [15:0] steps_remaining = '0;
   logic [7:0]  speed_seen      = '0;
   logic [7:0]  speed_wait      = '0;
   logic [1:0]  phase_now       = '0;
   logic [3:0]  coil_held       = '0;

   result_type  pending_results [$];
   int          error_count     = 0;
   int          quiet_cycles    = 0;
   int          send_idle_pct   = 0;
   int          rsp_stall_pct   = 0;
   logic        hold_off_request = 1'b0;

   stepper_step_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_enable       (req_enable),
      .req_direction    (req_direction),
      .req_speed        (req_speed),
      .req_step_target  (req_step_target),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coil_pattern (rsp_coil_pattern),
      .rsp_stepped      (rsp_stepped),
      .rsp_steps_left   (rsp_steps_left),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the motor model by one tick and return the result it shows.
   function automatic result_type step_motor(input item_type tick);
      result_type shown;
      logic       moved;
      moved = 1'b0;
      if (prescale_now < divide_setting) begin
         prescale_now = prescale_now + 8'd1;
      end else begin
         prescale_now = '0;
         if (tick.enable) begin
            if (target_seen != tick.step_target) begin
               target_seen     = tick.step_target;
               steps_remaining = tick.step_target;
            end else if (steps_remaining != '0) begin
               if (speed_seen != tick.speed) begin
                  speed_seen = tick.speed;
                  speed_wait = tick.speed;
               end else if (speed_wait != '0) begin
                  speed_wait = speed_wait - 8'd1;
               end else begin
                  coil_held       = FULL_STEP_COILS[phase_now];
                  speed_wait      = speed_seen;
                  phase_now       = tick.direction ? phase_now + 2'd1 : phase_now - 2'd1;
                  steps_remaining = steps_remaining - 16'd1;
                  moved           = 1'b1;
               end
            end
         end
      end
      shown.coil_pattern = coil_held;
      shown.stepped      = moved;
      shown.steps_left   = steps_remaining;
      return shown;
   endfunction

   // Check each accepted result, then predict for each accepted item.
   always @(posedge clock) begin
      result_type want;
      item_type   tick;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with nothing pending: coil %b stepped %b left %0d",
                        $time, rsp_coil_pattern, rsp_stepped, rsp_steps_left);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_coil_pattern !== want.coil_pattern) begin
                  $display("%0t: coil_pattern expected %b actual %b",
                           $time, want.coil_pattern, rsp_coil_pattern);
                  error_count++;
               end
               if (rsp_stepped !== want.stepped) begin
                  $display("%0t: stepped expected %b actual %b",
                           $time, want.stepped, rsp_stepped);
                  error_count++;
               end
               if (rsp_steps_left !== want.steps_left) begin
                  $display("%0t: steps_left expected %0d actual %0d",
                           $time, want.steps_left, rsp_steps_left);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            tick.enable      = req_enable;
            tick.direction   = req_direction;
            tick.speed       = req_speed;
            tick.step_target = req_step_target;
            pending_results.push_back(step_motor(tick));
         end
      end
   end

   // End the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Result receiver: random stalls, or a long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one tick after a random gap and hold it until accepted.
   task automatic send_tick(input logic en, input logic dir, input logic [7:0] spd,
                            input logic [15:0] tgt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_enable      <= en;
      req_direction   <= dir;
      req_speed       <= spd;
      req_step_target <= tgt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Pause the sender until every pending result is in, then let the pipe empty.
   task automatic settle_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of tick_divide: setup cycle, then access cycle.
   task automatic write_divide(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= TICK_DIVIDE_ADDR;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      divide_setting = value;
   endtask

   // Reset divide of two: load on the third tick, reverse wrap on the sixth.
   task automatic test_reset_divide();
      repeat (6) send_tick(1'b1, 1'b0, 8'd0, 16'd2);
   endtask

   // Step walk, no steps left, disabled, field extremes, speed reload, zero target.
   task automatic test_directed();
      settle_results();
      write_divide(8'd0);
      send_tick(1'b1, 1'b1, 8'd0,   16'd3);
      send_tick(1'b1, 1'b1, 8'd0,   16'd3);
      send_tick(1'b1, 1'b0, 8'd0,   16'd3);
      send_tick(1'b1, 1'b0, 8'd0,   16'd3);
      send_tick(1'b1, 1'b0, 8'd0,   16'd3);
      send_tick(1'b1, 1'b0, 8'd9,   16'd3);
      send_tick(1'b0, 1'b1, 8'd255, 16'd65535);
      send_tick(1'b1, 1'b1, 8'd255, 16'd65535);
      send_tick(1'b1, 1'b1, 8'd255, 16'd65535);
      send_tick(1'b1, 1'b1, 8'd1,   16'd65535);
      send_tick(1'b1, 1'b1, 8'd1,   16'd65535);
      send_tick(1'b1, 1'b1, 8'd1,   16'd65535);
      send_tick(1'b1, 1'b1, 8'd1,   16'd0);
      send_tick(1'b1, 1'b1, 8'd1,   16'd0);
      send_tick(1'b1, 1'b0, 8'd0,   16'd0);
   endtask

   // Lower the divide under a running prescaler: the next tick is an update.
   task automatic test_prescale_lowered();
      settle_results();
      write_divide(8'd9);
      repeat (6) send_tick(1'b1, 1'b1, 8'd0, 16'd5);
      settle_results();
      write_divide(8'd2);
      repeat (2) send_tick(1'b1, 1'b1, 8'd0, 16'd5);
   endtask

   // Random moves: hold target and speed over a run of ticks, with some noise.
   task automatic test_random_moves(input int count, input int idle_pct, input int stall_pct,
                                    input logic [7:0] divide);
      int          sent = 0;
      int          run_len;
      logic [15:0] tgt;
      logic [7:0]  spd;
      settle_results();
      write_divide(divide);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sent < count) begin
         if ($urandom_range(9) != 0) begin
            tgt     = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
            spd     = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            run_len = $urandom_range(4, 40);
            repeat (run_len) begin
               // occasionally retarget or change speed in the middle of a move
               if ($urandom_range(31) == 0) tgt = 16'($urandom_range(0, 12));
               if ($urandom_range(31) == 0) spd = 8'($urandom_range(0, 3));
               send_tick($urandom_range(15) != 0, 1'($urandom_range(1)), spd, tgt);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom),
                         16'($urandom));
               sent++;
            end
         end
      end
   endtask

   // Hold the receiver off while ticks keep coming, so the input backs up.
   task automatic test_backpressure();
      settle_results();
      write_divide(8'd0);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_request = 1'b1;
      repeat (40) send_tick(1'b1, 1'($urandom_range(1)), 8'd1, 16'd30);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_divide();
      test_directed();
      test_prescale_lowered();
      test_random_moves(300, 0, 0, 8'd0);
      test_random_moves(280, 48, 0, 8'd1);
      test_random_moves(280, 0, 48, 8'd3);
      test_random_moves(280, 12, 12, 8'($urandom_range(0, 5)));
      test_random_moves(280, 0, 0, 8'd255);
      test_backpressure();
      settle_results();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
